### rtl/core/flacc_pkg.sv
package flacc_pkg;

    localparam int unsigned LifeW  = 16;
    localparam int unsigned TickW  = 16;
    localparam int unsigned FanW   = 4;
    localparam int unsigned PmW    = 10;
    localparam int unsigned PctW   = 7;
    localparam int unsigned WtW    = 5;
    localparam int unsigned ProdW  = LifeW + PctW;
    localparam int unsigned StepCntW = 3;

    localparam int unsigned CfgIdxW  = 2;
    localparam int unsigned CfgDataW = 16;

    localparam int unsigned InDataW  = 16;
    localparam int unsigned OutDataW = 32;

    localparam logic [CfgIdxW-1:0] CFG_TOTAL_LIFE     = 2'd0;
    localparam logic [CfgIdxW-1:0] CFG_TICKS_PER_HOUR = 2'd1;
    localparam logic [CfgIdxW-1:0] CFG_FAST_MODE      = 2'd2;

    localparam logic [LifeW-1:0] TOTAL_LIFE_RST     = 16'd30000;
    localparam logic [TickW-1:0] TICKS_PER_HOUR_RST = 16'd3600;

    localparam logic [PctW-1:0] FULL_PERCENT = 7'd100;
    localparam logic [PctW-1:0] REPLACE_AT   = 7'd2;
    localparam logic [LifeW-1:0] SAT_USED    = 16'hFFFF;

    localparam logic [PmW-1:0] PM_BAND = 10'd50;
    localparam int unsigned    NumBands = 8;

    localparam logic [StepCntW-1:0] DIV_LAST_STEP = 3'(PctW - 1);

    typedef logic [WtW-1:0] weight_t;
    localparam weight_t WEIGHT_TABLE [0:NumBands] = '{
        5'd5, 5'd7, 5'd9, 5'd9, 5'd10, 5'd15, 5'd20, 5'd25, 5'd30
    };

    typedef struct packed {
        logic start;
        logic step;
        logic load;
    } ctrl_cmd_t;

    function automatic weight_t pick_weight(input logic [PmW-1:0] pm);
        logic [3:0] idx;
        idx = '0;
        for (int k = 1; k <= NumBands; k++) begin
            if (pm > PmW'(k * PM_BAND)) begin
                idx = idx + 4'd1;
            end
        end
        return WEIGHT_TABLE[idx];
    endfunction

endpackage

### rtl/core/flacc_ctrl.sv
module flacc_ctrl (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output flacc_pkg::ctrl_cmd_t cmd
);
    import flacc_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV,
        ST_HOLD
    } state_t;

    state_t               state_reg, state_next;
    logic [StepCntW-1:0]  cnt_reg, cnt_next;
    logic                 m_tvalid_reg, m_tvalid_next;
    logic                 out_free;

    assign out_free  = !m_tvalid_reg || m_tready;
    assign s_tready  = (state_reg == ST_IDLE);
    assign m_tvalid  = m_tvalid_reg;

    assign cmd.start = (state_reg == ST_IDLE) && s_tvalid;
    assign cmd.step  = (state_reg == ST_DIV);
    assign cmd.load  = (state_reg == ST_HOLD) && out_free;

    always_comb begin
        state_next    = state_reg;
        cnt_next      = cnt_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    state_next = ST_DIV;
                    cnt_next   = DIV_LAST_STEP;
                end
            end
            ST_DIV: begin
                if (cnt_reg == '0) begin
                    state_next = ST_HOLD;
                end else begin
                    cnt_next = cnt_reg - 1'b1;
                end
            end
            ST_HOLD: begin
                if (out_free) begin
                    state_next    = ST_IDLE;
                    m_tvalid_next = 1'b1;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            cnt_reg      <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            cnt_reg      <= cnt_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

endmodule

### rtl/core/flacc_dp.sv
module flacc_dp (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_wr_en,
    input  logic [flacc_pkg::CfgIdxW-1:0]  cfg_index,
    input  logic [flacc_pkg::CfgDataW-1:0] cfg_data,
    input  logic [flacc_pkg::InDataW-1:0]  s_tdata,
    input  flacc_pkg::ctrl_cmd_t           cmd,
    output logic [flacc_pkg::OutDataW-1:0] m_tdata
);
    import flacc_pkg::*;

    logic [LifeW-1:0] total_life_reg;
    logic [TickW-1:0] ticks_per_hour_reg;
    logic             fast_mode_reg;

    logic [TickW-1:0] hour_ticks_reg, hour_ticks_next;
    logic [LifeW-1:0] used_reg, used_next;
    logic             replace_reg, replace_next;

    logic [ProdW-1:0] rem_reg, rem_next;
    logic [ProdW-1:0] dvs_reg, dvs_next;
    logic [PctW-1:0]  quo_reg, quo_next;
    logic             full_reg, full_next;

    logic [LifeW-1:0] out_used_reg, out_used_next;
    logic [PctW-1:0]  out_pct_reg, out_pct_next;
    logic [PctW-1:0]  out_rem_reg, out_rem_next;

    logic             in_power;
    logic [FanW-1:0]  in_fan;
    logic [PmW-1:0]   in_pm;
    logic [TickW-1:0] ticks_inc;
    logic             hour_done;
    logic [LifeW:0]   used_sum;
    logic [LifeW-1:0] used_upd;
    logic [PctW-1:0]  pct;
    logic [PctW-1:0]  rem_pct;

    assign in_power = s_tdata[0];
    assign in_fan   = s_tdata[FanW:1];
    assign in_pm    = s_tdata[FanW+PmW:FanW+1];

    assign ticks_inc = hour_ticks_reg + 1'b1;
    assign used_sum  = {1'b0, used_reg} + (LifeW+1)'(pick_weight(in_pm));
    assign used_upd  = used_sum[LifeW] ? SAT_USED : used_sum[LifeW-1:0];

    assign pct     = full_reg ? FULL_PERCENT : quo_reg;
    assign rem_pct = FULL_PERCENT - pct;

    always_comb begin
        hour_ticks_next = hour_ticks_reg;
        used_next       = used_reg;
        replace_next    = replace_reg;
        rem_next        = rem_reg;
        dvs_next        = dvs_reg;
        quo_next        = quo_reg;
        full_next       = full_reg;
        out_used_next   = out_used_reg;
        out_pct_next    = out_pct_reg;
        out_rem_next    = out_rem_reg;
        hour_done       = 1'b0;

        if (cmd.start) begin
            if (in_power && in_fan != '0) begin
                if (used_reg < total_life_reg) begin
                    if (fast_mode_reg) begin
                        hour_done = 1'b1;
                    end else begin
                        hour_ticks_next = ticks_inc;
                        hour_done       = ticks_inc >= ticks_per_hour_reg;
                    end
                    if (hour_done) begin
                        hour_ticks_next = '0;
                        used_next       = used_upd;
                    end
                end
            end else begin
                hour_ticks_next = '0;
            end
            rem_next  = ProdW'(used_next) * ProdW'(FULL_PERCENT);
            dvs_next  = ProdW'({total_life_reg, {(PctW-1){1'b0}}});
            quo_next  = '0;
            full_next = used_next >= total_life_reg;
        end

        if (cmd.step) begin
            if (rem_reg >= dvs_reg) begin
                rem_next = rem_reg - dvs_reg;
                quo_next = {quo_reg[PctW-2:0], 1'b1};
            end else begin
                quo_next = {quo_reg[PctW-2:0], 1'b0};
            end
            dvs_next = dvs_reg >> 1;
        end

        if (cmd.load) begin
            out_used_next = used_reg;
            out_pct_next  = pct;
            out_rem_next  = rem_pct;
            if (rem_pct <= REPLACE_AT) begin
                replace_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            total_life_reg     <= TOTAL_LIFE_RST;
            ticks_per_hour_reg <= TICKS_PER_HOUR_RST;
            fast_mode_reg      <= 1'b0;
            hour_ticks_reg     <= '0;
            used_reg           <= '0;
            replace_reg        <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                unique case (cfg_index)
                    CFG_TOTAL_LIFE:     total_life_reg     <= cfg_data[LifeW-1:0];
                    CFG_TICKS_PER_HOUR: ticks_per_hour_reg <= cfg_data[TickW-1:0];
                    CFG_FAST_MODE:      fast_mode_reg      <= cfg_data[0];
                    default: ;
                endcase
            end
            hour_ticks_reg <= hour_ticks_next;
            used_reg       <= used_next;
            replace_reg    <= replace_next;
        end
    end

    always_ff @(posedge aclk) begin
        rem_reg      <= rem_next;
        dvs_reg      <= dvs_next;
        quo_reg      <= quo_next;
        full_reg     <= full_next;
        out_used_reg <= out_used_next;
        out_pct_reg  <= out_pct_next;
        out_rem_reg  <= out_rem_next;
    end

    assign m_tdata = {1'b0, replace_reg, out_rem_reg, out_pct_reg, out_used_reg};

endmodule

### rtl/core/filter_life_accumulator_core.sv
// Filter life accumulator core.
// Input stream (s_*): one word per one-second tick carrying power_on, fan_speed
// and pm25_level. Output stream (m_*): one word per input word with used time,
// used and remaining percent of the filter life, and the sticky replace flag.
// Configuration: write total_life (0), ticks_per_hour (1) or fast_mode (2) via
// cfg_wr_en/cfg_index/cfg_data while no word is in flight; other indexes drop.
// Flow: the accepting edge updates the hour counter and used time, then the
// restoring divider runs seven steps for the percent (one quotient bit per
// edge), and a final edge loads the output register and raises m_tvalid.
// A word passes accept, the seven divider steps and load before the next
// word is taken.
// s_tready is high while the core is idle; a new word is taken even while the
// previous result still waits in the output register.
// Receiver stall: the finished result holds in the divider until the output
// register frees up; s_tready stays low meanwhile.
// Reset: synchronous, active low; clears the counters and the replace flag and
// restores total_life 30000, ticks_per_hour 3600, fast_mode off.
module filter_life_accumulator_core (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_wr_en,
    input  logic [flacc_pkg::CfgIdxW-1:0]  cfg_index,
    input  logic [flacc_pkg::CfgDataW-1:0] cfg_data,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // [0] power_on, [4:1] fan_speed, [14:5] pm25_level
    input  logic [flacc_pkg::InDataW-1:0]  s_tdata,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // [15:0] used_time, [22:16] used_percent, [29:23] remaining_percent,
    // [30] replace_needed
    output logic [flacc_pkg::OutDataW-1:0] m_tdata
);
    import flacc_pkg::*;

    ctrl_cmd_t cmd;

    flacc_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd)
    );

    flacc_dp u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tdata   (s_tdata),
        .cmd       (cmd),
        .m_tdata   (m_tdata)
    );

endmodule

### sim/filter_life_accumulator_core_test.sv
module filter_life_accumulator_core_test;
    timeunit 1ns;
    timeprecision 1ps;

    import flacc_pkg::*;

    localparam int unsigned IdlePct     = 18;
    localparam int unsigned CalmFrom    = 400;
    localparam int unsigned CalmTo      = 700;
    localparam int unsigned HoldAt      = 200;
    localparam int unsigned HoldLen     = 300;
    localparam int unsigned QuietLimit  = 4000;
    localparam int unsigned DrainCycles = 40;

    localparam logic [CfgIdxW-1:0] CFG_UNUSED = 2'd3;

    typedef enum logic [1:0] {
        FEED_TICK,
        FEED_CFG,
        FEED_CFG_REL
    } feed_kind_t;

    typedef struct {
        feed_kind_t           kind;
        logic                 power;
        logic [FanW-1:0]      fan;
        logic [PmW-1:0]       pm;
        logic [CfgIdxW-1:0]   idx;
        logic [CfgDataW-1:0]  value;
    } feed_t;

    typedef struct packed {
        logic [LifeW-1:0] used;
        logic [PctW-1:0]  used_pct;
        logic [PctW-1:0]  left_pct;
        logic             replace;
    } life_report_t;

    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  cfg_wr_en = 1'b0;
    logic [CfgIdxW-1:0]    cfg_index = '0;
    logic [CfgDataW-1:0]   cfg_data  = '0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [InDataW-1:0]    s_tdata   = '0;
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [OutDataW-1:0]   m_tdata;

    feed_t        sensor_feed[$];
    life_report_t due_reports[$];

    // predicted block state and settings
    logic [LifeW-1:0] life_budget = TOTAL_LIFE_RST;
    logic [TickW-1:0] hour_len    = TICKS_PER_HOUR_RST;
    logic             fast_hours  = 1'b0;
    logic [TickW-1:0] run_ticks   = '0;
    logic [LifeW-1:0] used_tenths = '0;
    logic             replace_flag = 1'b0;

    logic        s_fire = 1'b0;
    logic        calm;
    int unsigned ticks_taken     = 0;
    int unsigned reports_checked = 0;
    int unsigned cfg_writes      = 0;
    int unsigned replace_reports = 0;
    int unsigned peak_used       = 0;
    int unsigned mismatches      = 0;
    int unsigned quiet_cycles    = 0;
    int unsigned hold_left       = 0;
    logic        hold_used       = 1'b0;

    assign calm = (ticks_taken >= CalmFrom) && (ticks_taken < CalmTo);

    filter_life_accumulator_core i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    always #2 aclk = ~aclk;

    function automatic int unsigned hour_weight(logic [PmW-1:0] pm);
        int unsigned band;
        if (pm == '0) band = 0;
        else if (pm > 10'd450) band = 8;
        else band = (32'(pm) - 1) / 50;
        case (band)
            0: return 5;
            1: return 7;
            2, 3: return 9;
            4: return 10;
            5: return 15;
            6: return 20;
            7: return 25;
            default: return 30;
        endcase
    endfunction

    function automatic life_report_t account_tick(logic power, logic [FanW-1:0] fan,
                                                  logic [PmW-1:0] pm);
        life_report_t rep;
        logic [LifeW:0] sum;
        logic           hour_done;
        int unsigned    pct;
        if (power && fan != '0) begin
            if (used_tenths < life_budget) begin
                if (fast_hours) begin
                    hour_done = 1'b1;
                end else begin
                    run_ticks = run_ticks + 1'b1;
                    hour_done = run_ticks >= hour_len;
                end
                if (hour_done) begin
                    sum = {1'b0, used_tenths} + (LifeW + 1)'(hour_weight(pm));
                    run_ticks = '0;
                    used_tenths = sum[LifeW] ? SAT_USED : sum[LifeW-1:0];
                end
            end
        end else begin
            run_ticks = '0;
        end
        if (used_tenths >= life_budget) pct = 100;
        else pct = (32'(used_tenths) * 100) / 32'(life_budget);
        if (100 - pct <= 2) replace_flag = 1'b1;
        rep.used     = used_tenths;
        rep.used_pct = PctW'(pct);
        rep.left_pct = PctW'(100 - pct);
        rep.replace  = replace_flag;
        return rep;
    endfunction

    function automatic void check_field(string what, int unsigned want, int unsigned got);
        if (want != got) begin
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, what, want, got);
            mismatches++;
        end
    endfunction

    function automatic void push_tick(logic power, logic [FanW-1:0] fan, logic [PmW-1:0] pm);
        feed_t it;
        it.kind  = FEED_TICK;
        it.power = power;
        it.fan   = fan;
        it.pm    = pm;
        it.idx   = '0;
        it.value = '0;
        sensor_feed.push_back(it);
    endfunction

    function automatic void push_cfg(feed_kind_t kind, logic [CfgIdxW-1:0] idx,
                                     logic [CfgDataW-1:0] value);
        feed_t it;
        it.kind  = kind;
        it.power = 1'b0;
        it.fan   = '0;
        it.pm    = '0;
        it.idx   = idx;
        it.value = value;
        sensor_feed.push_back(it);
    endfunction

    function automatic void push_fast(logic on);
        push_cfg(FEED_CFG, CFG_FAST_MODE, (CfgDataW'($urandom) & 16'hFFFE) | CfgDataW'(on));
    endfunction

    function automatic void push_random_tick(int unsigned run_pct, logic high_pm);
        logic [PmW-1:0]  pm;
        logic [FanW-1:0] fan;
        logic            power;
        if (high_pm) pm = PmW'($urandom_range(451, 1023));
        else if ($urandom_range(99) < 30) pm = PmW'($urandom_range(0, 9) * 50 + $urandom_range(0, 1));
        else pm = PmW'($urandom_range(0, 1023));
        if ($urandom_range(99) < run_pct) begin
            power = 1'b1;
            fan   = FanW'($urandom_range(1, 15));
        end else if ($urandom_range(0, 1)) begin
            power = 1'b0;
            fan   = FanW'($urandom_range(0, 15));
        end else begin
            power = 1'b1;
            fan   = '0;
        end
        push_tick(power, fan, pm);
    endfunction

    // drive input words and register writes
    always @(negedge aclk) begin : drive
        feed_t               it;
        logic                nvalid;
        logic [InDataW-1:0]  ndata;
        logic                nwr;
        logic [CfgIdxW-1:0]  nidx;
        logic [CfgDataW-1:0] nval;
        logic [LifeW:0]      rel_sum;
        nvalid = s_tvalid && !s_fire;
        ndata  = s_tdata;
        nwr    = 1'b0;
        nidx   = cfg_index;
        nval   = cfg_data;
        if (aresetn && !nvalid && sensor_feed.size() > 0) begin
            it = sensor_feed[0];
            if (it.kind == FEED_TICK) begin
                if (calm || $urandom_range(99) >= IdlePct) begin
                    nvalid = 1'b1;
                    ndata  = {1'b0, it.pm, it.fan, it.power};
                    void'(sensor_feed.pop_front());
                end
            end else if (due_reports.size() == 0) begin
                nwr  = 1'b1;
                nidx = it.idx;
                if (it.kind == FEED_CFG_REL) begin
                    rel_sum = {1'b0, used_tenths} + {1'b0, it.value};
                    nval = rel_sum[LifeW] ? SAT_USED : rel_sum[LifeW-1:0];
                end else begin
                    nval = it.value;
                end
                void'(sensor_feed.pop_front());
            end
        end
        s_tvalid  <= nvalid;
        s_tdata   <= ndata;
        cfg_wr_en <= nwr;
        cfg_index <= nidx;
        cfg_data  <= nval;
    end

    // result side backpressure, with one long hold-off
    always @(negedge aclk) begin : sink
        if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            m_tready  <= 1'b0;
        end else if (!hold_used && ticks_taken >= HoldAt) begin
            hold_used <= 1'b1;
            hold_left <= HoldLen;
            m_tready  <= 1'b0;
        end else begin
            m_tready <= calm || ($urandom_range(99) >= IdlePct);
        end
    end

    always @(posedge aclk) begin : watch
        life_report_t want;
        logic         took;
        logic         gave;
        took = aresetn && s_tvalid && s_tready;
        gave = aresetn && m_tvalid && m_tready;
        s_fire <= took;
        if (aresetn) begin
            if (cfg_wr_en) begin
                cfg_writes++;
                case (cfg_index)
                    CFG_TOTAL_LIFE:     life_budget = cfg_data;
                    CFG_TICKS_PER_HOUR: hour_len    = cfg_data;
                    CFG_FAST_MODE:      fast_hours  = cfg_data[0];
                    default: ;
                endcase
            end
            if (took) begin
                ticks_taken++;
                due_reports.push_back(account_tick(s_tdata[0], s_tdata[4:1], s_tdata[14:5]));
            end
            if (gave) begin
                if (due_reports.size() == 0) begin
                    $display("%0t: unexpected result word, expected none, got %h", $time, m_tdata);
                    mismatches++;
                end else begin
                    want = due_reports.pop_front();
                    reports_checked++;
                    if (want.replace) replace_reports++;
                    if (want.used > peak_used) peak_used = want.used;
                    check_field("used_time", want.used, m_tdata[15:0]);
                    check_field("used_percent", want.used_pct, m_tdata[22:16]);
                    check_field("remaining_percent", want.left_pct, m_tdata[29:23]);
                    check_field("replace_needed", want.replace, m_tdata[30]);
                end
            end
            if (took || gave || cfg_wr_en) quiet_cycles = 0;
            else quiet_cycles++;
            if (quiet_cycles >= QuietLimit) begin
                $display("%0t: no word moved for %0d cycles", $time, QuietLimit);
                $display("filter_life_accumulator_core_test failed");
                $finish;
            end
        end
    end

    initial begin : scenario
        int unsigned    n;
        logic [PmW-1:0] band_pm [14];
        // reset settings: hour of 3600 ticks never completes here
        push_tick(1'b1, 4'd1, 10'd0);
        push_tick(1'b1, 4'd15, 10'd1023);
        push_tick(1'b0, 4'd15, 10'd1023);
        push_tick(1'b1, 4'd0, 10'd512);
        push_tick(1'b1, 4'd7, 10'd300);
        push_tick(1'b1, 4'd9, 10'd451);

        // every weight band in fast mode, plus stopped unit
        push_cfg(FEED_CFG, CFG_TOTAL_LIFE, 16'hFFFF);
        push_fast(1'b1);
        push_cfg(FEED_CFG, CFG_UNUSED, 16'h0000);
        band_pm = '{10'd0, 10'd1, 10'd50, 10'd51, 10'd101, 10'd151, 10'd201, 10'd251,
                    10'd301, 10'd351, 10'd401, 10'd450, 10'd451, 10'd1023};
        for (int k = 0; k < 14; k++)
            push_tick(1'b1, FanW'($urandom_range(1, 15)), band_pm[k]);
        push_tick(1'b0, 4'd15, 10'd1023);
        push_tick(1'b1, 4'd0, 10'd1023);

        // hour counter cleared by a stop, then a lowered hour length
        push_fast(1'b0);
        push_cfg(FEED_CFG, CFG_TICKS_PER_HOUR, 16'd3);
        push_tick(1'b1, 4'd3, 10'd200);
        push_tick(1'b0, 4'd3, 10'd200);
        push_tick(1'b1, 4'd3, 10'd200);
        push_tick(1'b1, 4'd3, 10'd200);
        push_tick(1'b1, 4'd3, 10'd200);
        push_cfg(FEED_CFG, CFG_TICKS_PER_HOUR, 16'd6);
        push_tick(1'b1, 4'd8, 10'd20);
        push_tick(1'b1, 4'd8, 10'd20);
        push_tick(1'b1, 4'd8, 10'd20);
        push_cfg(FEED_CFG, CFG_TICKS_PER_HOUR, 16'd2);
        push_tick(1'b1, 4'd8, 10'd20);

        for (int ph = 0; ph < 8; ph++) begin
            case (ph)
                0: push_cfg(FEED_CFG, CFG_TOTAL_LIFE, 16'hFFFF);
                1, 2: push_cfg(FEED_CFG, CFG_TOTAL_LIFE, LifeW'($urandom_range(40000, 65535)));
                5: push_cfg(FEED_CFG_REL, CFG_TOTAL_LIFE, 16'd0);
                6: push_cfg(FEED_CFG, CFG_TOTAL_LIFE, 16'd1);
                default: push_cfg(FEED_CFG_REL, CFG_TOTAL_LIFE, LifeW'($urandom_range(0, 1500)));
            endcase
            case ($urandom_range(0, 4))
                0: push_cfg(FEED_CFG, CFG_TICKS_PER_HOUR, 16'd0);
                1: push_cfg(FEED_CFG, CFG_TICKS_PER_HOUR, 16'd1);
                2: push_cfg(FEED_CFG, CFG_TICKS_PER_HOUR, 16'hFFFF);
                default: push_cfg(FEED_CFG, CFG_TICKS_PER_HOUR, TickW'($urandom_range(2, 12)));
            endcase
            push_fast(ph == 0 ? 1'b1 : 1'($urandom_range(0, 1)));
            n = $urandom_range(50, 70);
            repeat (n) push_random_tick(85, 1'b0);
        end

        push_cfg(FEED_CFG, CFG_TOTAL_LIFE, 16'd0);
        repeat (10) push_random_tick(85, 1'b0);

        // push used time high at the heaviest weight
        push_cfg(FEED_CFG, CFG_TOTAL_LIFE, 16'hFFFF);
        push_cfg(FEED_CFG, CFG_TICKS_PER_HOUR, TickW'($urandom_range(0, 65535)));
        push_fast(1'b1);
        repeat (1150) push_random_tick(97, 1'b1);
        repeat (10) push_random_tick(85, 1'b0);

        repeat (12) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        while (sensor_feed.size() > 0 || s_tvalid || due_reports.size() > 0)
            @(posedge aclk);
        repeat (DrainCycles) @(posedge aclk);

        $display("run covered %0d sensor ticks and %0d register writes, %0d results checked",
                 ticks_taken, cfg_writes, reports_checked);
        $display("used time peaked at %0d tenths, replace flag up in %0d results",
                 peak_used, replace_reports);
        if (mismatches == 0) begin
            $display("filter_life_accumulator_core_test passed");
        end else begin
            $display("filter_life_accumulator_core_test failed");
        end
        $finish;
    end

endmodule

### files.f
rtl/core/flacc_pkg.sv
rtl/core/flacc_ctrl.sv
rtl/core/flacc_dp.sv
rtl/core/filter_life_accumulator_core.sv
sim/filter_life_accumulator_core_test.sv
